FILE: design/qgh_pkg.sv
// Shared constants, types and arithmetic helpers of the quaternion gravity/heading unit.
package qgh_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int IN_W       = 16;
	localparam int OUT_W      = FRAC_BITS + 2;
	localparam int IN_DATA_W  = 4 * IN_W;
	localparam int OUT_DATA_W = 5 * OUT_W;

	localparam int CW     = IN_W + 1;     // scaled component
	localparam int PW     = 2 * CW;       // component product
	localparam int SW     = PW + 1;       // quadratic form sums
	localparam int N2W    = 33;           // squared norm, at most 2^32
	localparam int HW     = 33;           // heading pair after block scaling
	localparam int MW     = 31;           // heading magnitude, below 2^31
	localparam int RW     = 64;           // root radicand and partial root
	localparam int HROOTW = 32;           // root result

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = OUT_W;
	localparam int DEN_W     = 34;
	localparam int DVD_W     = DEN_W + DIV_STEPS;
	localparam int LANES     = 5;

	// s1..s7, root stages 0..SQ_STEPS, divider stages 0..DIV_STEPS, output
	localparam int PIPE_DEPTH = 7 + (SQ_STEPS + 1) + (DIV_STEPS + 1) + 1;

	localparam logic [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;

	typedef logic signed [CW-1:0] comp_t;

	// values that ride along the root stages
	typedef struct packed {
		logic [2:0][DVD_W-1:0] gdvd;
		logic [2:0]            gneg;
		logic [N2W-1:0]        n2;
		logic                  hz;
		logic                  fb;
	} carry_t;

	typedef struct packed {
		logic [MW-1:0] amag;
		logic [MW-1:0] bmag;
		logic          aneg;
		logic          bneg;
	} head_t;

	typedef struct packed {
		logic [RW-1:0] v;
		logic [RW-1:0] r;
	} root_t;

	function automatic logic [SW-1:0] smag(input logic signed [SW-1:0] v);
		return v[SW-1] ? SW'(-v) : SW'(v);
	endfunction

	function automatic logic [HW-1:0] hmag(input logic signed [HW-1:0] v);
		return v[HW-1] ? HW'(-v) : HW'(v);
	endfunction

	// one digit of the square root recurrence
	function automatic root_t root_step(input root_t s, input logic [RW-1:0] bw);
		root_t         o;
		logic [RW-1:0] t;
		t = s.r + bw;
		if (s.v >= t) begin
			o.v = s.v - t;
			o.r = (s.r >> 1) + bw;
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	// one restoring division step: remainder on top, dividend/quotient bits below
	function automatic logic [DVD_W-1:0] div_step(input logic [DVD_W-1:0] w,
			input logic [DEN_W-1:0] d);
		logic [DEN_W:0] t;
		logic [DEN_W:0] r;
		logic           ge;
		t  = {w[DVD_W-1:DIV_STEPS], w[DIV_STEPS-1]};
		ge = (t >= {1'b0, d});
		r  = ge ? t - {1'b0, d} : t;
		return {r[DEN_W-1:0], w[DIV_STEPS-2:0], ge};
	endfunction

	function automatic logic [OUT_W-1:0] sat_sign(input logic [DIV_STEPS-1:0] q,
			input logic neg);
		logic [OUT_W-1:0] m;
		m = (OUT_W'(q) > ONE_Q) ? ONE_Q : OUT_W'(q);
		return neg ? OUT_W'(-m) : m;
	endfunction

endpackage

FILE: design/quat_gravity_heading_unit.sv
// Top level: pipelined quaternion to body-frame gravity and world-plane heading.
// The unit takes one quaternion word per cycle and returns one result word per
// quaternion. The depth is set by the 32-stage square root of the heading norm
// (one root digit per stage) followed by a 16-stage restoring divider (one
// quotient bit per stage) that serves all five outputs in parallel.
// The quaternion is block-scaled to [2^14, 2^15], the quadratic forms are
// formed, gravity is each form over the squared norm and heading is A/h, B/h
// with h = floor(sqrt(A^2+B^2)). Quotients round to nearest, ties away from
// zero, and saturate to +-1.0 in Q1.14. An all-zero quaternion is replaced by
// identity and flagged on m_tuser; a vertical body x axis gives heading (0,0).
// A stall on the output freezes the whole pipe, so s_tready follows m_tready
// whenever the last stage holds a word.
module quat_gravity_heading_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [qgh_pkg::IN_DATA_W-1:0]   s_tdata,  // quat_w, quat_x, quat_y, quat_z
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [qgh_pkg::OUT_DATA_W-1:0]  m_tdata,  // grav_x, grav_y, grav_z, head_x, head_y
	output logic                            m_tuser   // fell_back
);
	import qgh_pkg::*;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_s;

	assign en       = !vld_s[PIPE_DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], s_tvalid};
		end
	end

	// ---- s1: unpack, largest magnitude, zero fallback
	comp_t         ci [4];
	logic [CW-1:0] mi;
	logic          fbi;
	comp_t         c_s1 [4];
	logic [CW-1:0] m_s1;
	logic          fb_s1;

	always_comb begin
		logic [CW-1:0] mg;
		mi = '0;
		for (int i = 0; i < 4; i++) begin
			ci[i] = CW'($signed(s_tdata[i*IN_W +: IN_W]));
			mg    = ci[i][CW-1] ? CW'(-ci[i]) : CW'(ci[i]);
			if (mg > mi) mi = mg;
		end
		fbi = (mi == '0);
		if (fbi) begin
			ci[0] = CW'(1) << FRAC_BITS;
			mi    = CW'(1) << FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= ci;
			m_s1  <= mi;
			fb_s1 <= fbi;
		end
	end

	// ---- s2: scale up until the largest magnitude reaches 2^14
	logic [3:0] k2;
	comp_t      c_s2 [4];
	logic       fb_s2;

	always_comb begin
		int p;
		p = 0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			if (m_s1[i]) p = i;
		end
		k2 = (m_s1 >= (CW'(1) << FRAC_BITS)) ? 4'd0 : 4'(FRAC_BITS - p);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) c_s2[i] <= c_s1[i] <<< k2;
			fb_s2 <= fb_s1;
		end
	end

	// ---- s3: products
	logic signed [PW-1:0] ww_s3, xx_s3, yy_s3, zz_s3, wy_s3, xz_s3, wx_s3, yz_s3, wz_s3, xy_s3;
	logic                 fb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s3 <= c_s2[0] * c_s2[0];
			xx_s3 <= c_s2[1] * c_s2[1];
			yy_s3 <= c_s2[2] * c_s2[2];
			zz_s3 <= c_s2[3] * c_s2[3];
			wy_s3 <= c_s2[0] * c_s2[2];
			xz_s3 <= c_s2[1] * c_s2[3];
			wx_s3 <= c_s2[0] * c_s2[1];
			yz_s3 <= c_s2[2] * c_s2[3];
			wz_s3 <= c_s2[0] * c_s2[3];
			xy_s3 <= c_s2[1] * c_s2[2];
			fb_s3 <= fb_s2;
		end
	end

	// ---- s4: quadratic forms
	logic signed [SW-1:0] n2w;
	logic [N2W-1:0]       n2_s4;
	logic signed [SW-1:0] g_s4 [3];
	logic signed [SW-1:0] a_s4, b_s4;
	logic                 fb_s4;

	assign n2w = SW'(ww_s3) + SW'(xx_s3) + SW'(yy_s3) + SW'(zz_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s4   <= n2w[N2W-1:0];
			g_s4[0] <= (SW'(wy_s3) - SW'(xz_s3)) <<< 1;
			g_s4[1] <= -((SW'(wx_s3) + SW'(yz_s3)) <<< 1);
			g_s4[2] <= SW'(xx_s3) + SW'(yy_s3) - SW'(ww_s3) - SW'(zz_s3);
			a_s4    <= SW'(ww_s3) + SW'(xx_s3) - SW'(yy_s3) - SW'(zz_s3);
			b_s4    <= (SW'(wz_s3) + SW'(xy_s3)) <<< 1;
			fb_s4   <= fb_s3;
		end
	end

	// ---- s5: gravity dividends (rounding half folded in), heading scaled down
	localparam logic [SW-1:0] LIM31 = SW'(1) << 31;

	logic signed [SW-1:0] a5n, b5n;
	carry_t               cr5;
	carry_t               cr_s5;
	logic signed [HW-1:0] a_s5, b_s5;

	always_comb begin
		logic signed [SW-1:0] a1, b1, a2, b2;
		a1 = a_s4 >>> 1;
		b1 = b_s4 >>> 1;
		a2 = a_s4 >>> 2;
		b2 = b_s4 >>> 2;
		if (smag(a_s4) < LIM31 && smag(b_s4) < LIM31) begin
			a5n = a_s4;
			b5n = b_s4;
		end else if (smag(a1) < LIM31 && smag(b1) < LIM31) begin
			a5n = a1;
			b5n = b1;
		end else begin
			a5n = a2;
			b5n = b2;
		end
		for (int i = 0; i < 3; i++) begin
			cr5.gdvd[i] = (DVD_W'(smag(g_s4[i])) << FRAC_BITS) + DVD_W'(n2_s4 >> 1);
			cr5.gneg[i] = g_s4[i][SW-1];
		end
		cr5.n2 = n2_s4;
		cr5.hz = (a_s4 == '0) && (b_s4 == '0);
		cr5.fb = fb_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s5 <= cr5;
			a_s5  <= HW'(a5n);
			b_s5  <= HW'(b5n);
		end
	end

	// ---- s6: heading scaled up until the larger magnitude reaches 2^29
	logic [HW-1:0]        ma6;
	logic [4:0]           k6;
	logic signed [HW-1:0] a_s6, b_s6;
	carry_t               cr_s6;

	always_comb begin
		int p;
		ma6 = (hmag(a_s5) > hmag(b_s5)) ? hmag(a_s5) : hmag(b_s5);
		p   = 0;
		for (int i = 0; i < 29; i++) begin
			if (ma6[i]) p = i;
		end
		k6 = (ma6 >= (HW'(1) << 29) || ma6 == '0) ? 5'd0 : 5'(29 - p);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s6  <= a_s5 <<< k6;
			b_s6  <= b_s5 <<< k6;
			cr_s6 <= cr_s5;
		end
	end

	// ---- s7: squares of the heading pair
	head_t           hd7;
	head_t           hd_s7;
	logic [2*MW-1:0] sqa_s7, sqb_s7;
	carry_t          cr_s7;

	assign hd7.amag = MW'(hmag(a_s6));
	assign hd7.bmag = MW'(hmag(b_s6));
	assign hd7.aneg = a_s6[HW-1];
	assign hd7.bneg = b_s6[HW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s7  <= hd7;
			sqa_s7 <= hd7.amag * hd7.amag;
			sqb_s7 <= hd7.bmag * hd7.bmag;
			cr_s7  <= cr_s6;
		end
	end

	// ---- root stages: index 0 holds the radicand, one digit per stage
	root_t  rt_s [SQ_STEPS+1];
	root_t  rt_n [SQ_STEPS];
	carry_t cr_sq_s [SQ_STEPS+1];
	head_t  hd_sq_s [SQ_STEPS+1];

	always_comb begin
		for (int i = 0; i < SQ_STEPS; i++) begin
			rt_n[i] = root_step(rt_s[i], RW'(1) << (2 * (SQ_STEPS - 1 - i)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0].v  <= RW'(sqa_s7) + RW'(sqb_s7);
			rt_s[0].r  <= '0;
			cr_sq_s[0] <= cr_s7;
			hd_sq_s[0] <= hd_s7;
			for (int i = 0; i < SQ_STEPS; i++) begin
				rt_s[i+1]    <= rt_n[i];
				cr_sq_s[i+1] <= cr_sq_s[i];
				hd_sq_s[i+1] <= hd_sq_s[i];
			end
		end
	end

	// ---- divider stages: lanes 0..2 gravity over n2, lanes 3..4 heading over h
	logic [HROOTW-1:0] h_root;
	logic [DVD_W-1:0]  dw_s [DIV_STEPS+1][LANES];
	logic [DEN_W-1:0]  dg_s [DIV_STEPS+1];
	logic [DEN_W-1:0]  dh_s [DIV_STEPS+1];
	logic [LANES-1:0]  neg_s [DIV_STEPS+1];
	logic              hz_s [DIV_STEPS+1];
	logic              fb_s [DIV_STEPS+1];
	carry_t            crf;
	head_t             hdf;

	assign h_root = rt_s[SQ_STEPS].r[HROOTW-1:0];
	assign crf    = cr_sq_s[SQ_STEPS];
	assign hdf    = hd_sq_s[SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) dw_s[0][l] <= crf.gdvd[l];
			dw_s[0][3] <= (DVD_W'(hdf.amag) << FRAC_BITS) + DVD_W'(h_root >> 1);
			dw_s[0][4] <= (DVD_W'(hdf.bmag) << FRAC_BITS) + DVD_W'(h_root >> 1);
			dg_s[0]    <= DEN_W'(crf.n2);
			dh_s[0]    <= DEN_W'(h_root);
			neg_s[0]   <= {hdf.bneg, hdf.aneg, crf.gneg};
			hz_s[0]    <= crf.hz;
			fb_s[0]    <= crf.fb;
			for (int j = 0; j < DIV_STEPS; j++) begin
				for (int l = 0; l < LANES; l++) begin
					dw_s[j+1][l] <= div_step(dw_s[j][l], (l < 3) ? dg_s[j] : dh_s[j]);
				end
				dg_s[j+1]  <= dg_s[j];
				dh_s[j+1]  <= dh_s[j];
				neg_s[j+1] <= neg_s[j];
				hz_s[j+1]  <= hz_s[j];
				fb_s[j+1]  <= fb_s[j];
			end
		end
	end

	// ---- output register: saturate, apply sign, vertical heading gives zero
	logic [OUT_W-1:0] res [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l] = sat_sign(dw_s[DIV_STEPS][l][DIV_STEPS-1:0], neg_s[DIV_STEPS][l]);
		end
		if (hz_s[DIV_STEPS]) begin
			res[3] = '0;
			res[4] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {res[4], res[3], res[2], res[1], res[0]};
			m_tuser <= fb_s[DIV_STEPS];
		end
	end

`ifndef NO_ASSERTIONS
	// fallback word must be identity: gravity (0,0,-1), heading (1,0)
	a_fallback_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			m_tdata[15:0] == '0 && m_tdata[31:16] == '0 &&
			m_tdata[47:32] == OUT_W'(-ONE_Q) &&
			m_tdata[63:48] == ONE_Q && m_tdata[79:64] == '0)
		else $error("fallback word is not identity");

	// a held result stalls the whole pipe
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// gravity z never leaves +-1.0
	a_grav_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[47:32]) <= $signed(ONE_Q) &&
			$signed(m_tdata[47:32]) >= -$signed(ONE_Q))
		else $error("grav_z out of range");
`endif

endmodule
